// File: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// tcw_pkg: shared types and constants of the text console cell writer
// no dependencies; used by the interfaces, the controller and the top level

package tcw_pkg;

  // command codes
  localparam logic [2:0] CmdPut   = 3'd0;
  localparam logic [2:0] CmdBack  = 3'd1;
  localparam logic [2:0] CmdGoto  = 3'd2;
  localparam logic [2:0] CmdClear = 3'd3;
  localparam logic [2:0] CmdRead  = 3'd4;

  // special character codes
  localparam logic [7:0] ChTab     = 8'd9;
  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChSpace   = 8'd32;

  // blanks written for one tab
  localparam int TabBlanks = 4;
  localparam int RemW      = $clog2(TabBlanks + 1);

  // configuration register indexes
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CfgFore = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgBack = 4'd1;

  localparam logic [3:0] ForeReset = 4'd15;
  localparam logic [3:0] BackReset = 4'd0;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
    logic [6:0] bound;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] cell_value;
    logic        screen_cleared;
  } res_t;

endpackage

// File: rtl/core/tcw_if.sv
`timescale 1ns / 1ps
// tcw_if: valid/ready channel interfaces for commands, results and config writes
// depends on tcw_pkg for the config field widths

interface tcw_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] char_code;
  logic [6:0] col;
  logic [4:0] row;
  logic [6:0] bound;

  modport source (output valid, cmd, char_code, col, row, bound, input ready);
  modport sink   (input valid, cmd, char_code, col, row, bound, output ready);
endinterface

interface tcw_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [15:0] cell_value;
  logic        screen_cleared;

  modport source (output valid, cursor_col, cursor_row, cell_value, screen_cleared,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_value, screen_cleared,
                  output ready);
endinterface

interface tcw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::CfgIdxW-1:0]  index;
  logic [tcw_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/core/text_console_cell_writer_core.sv
`timescale 1ns / 1ps
// text console cell writer, top level: config registers, result word register
// steps to result valid: accept, EXEC, then PUT per written cell (a tab writes four
//   blanks), BS2 for a moving backspace or RD for a read, then DONE
// clear, or newline/advance off the last row: a clearing sweep over every cell as well
// flow: one command at a time; the next is accepted only after its result word is valid
// reset: cursor homes, colors 15/0, a sweep zeroes every cell, cmd ready low

module text_console_cell_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_cmd_if.sink   cmd_i,
  tcw_res_if.source res_o,
  tcw_cfg_if.sink   cfg_i
);

  localparam int Cells = COLUMNS * ROWS;
  localparam int PosW  = $clog2(Cells);

  logic [3:0]      fore_q, back_q;
  cmd_t            cmd_word;
  res_t            ctrl_res, res_q;
  logic            ctrl_valid, slot_free, res_valid_q;
  logic            mem_we, mem_re;
  logic [PosW-1:0] mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata, mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q <= ForeReset;
      back_q <= BackReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgFore) begin
        fore_q <= cfg_i.wdata;
      end else if (cfg_i.index == CfgBack) begin
        back_q <= cfg_i.wdata;
      end
    end
  end

  assign cmd_word = '{cmd:       cmd_i.cmd,
                      char_code: cmd_i.char_code,
                      col:       cmd_i.col,
                      row:       cmd_i.row,
                      bound:     cmd_i.bound};

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .PosW    (PosW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .cmd_i       (cmd_word),
    .fore_i      (fore_q),
    .back_i      (back_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (ctrl_valid),
    .res_ready_i (slot_free),
    .res_o       (ctrl_res)
  );

  tcw_screen_mem #(
    .Depth (Cells),
    .AddrW (PosW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result word register
  assign slot_free = !res_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (slot_free) begin
      res_valid_q <= ctrl_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && ctrl_valid) begin
      res_q <= ctrl_res;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.cursor_col     = res_q.cursor_col;
  assign res_o.cursor_row     = res_q.cursor_row;
  assign res_o.cell_value     = res_q.cell_value;
  assign res_o.screen_cleared = res_q.screen_cleared;

endmodule

// File: rtl/core/tcw_screen_mem.sv
`timescale 1ns / 1ps
// tcw_screen_mem: screen cell store, one write and one read port,
// registered read data; no dependencies

module tcw_screen_mem #(
  parameter int Depth = 2000,
  parameter int AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [15:0]      rdata_o
);

  logic [15:0] mem_q [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tcw_ctrl.sv
`timescale 1ns / 1ps
// tcw_ctrl: command sequencer, cursor and write position, clearing sweep
// depends on tcw_pkg; drives the ports of tcw_screen_mem

module tcw_ctrl import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int PosW    = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  input  logic [3:0]      fore_i,
  input  logic [3:0]      back_i,
  output logic            mem_we_o,
  output logic [PosW-1:0] mem_waddr_o,
  output logic [15:0]     mem_wdata_o,
  output logic            mem_re_o,
  output logic [PosW-1:0] mem_raddr_o,
  input  logic [15:0]     mem_rdata_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output res_t            res_o
);

  localparam int Cells = COLUMNS * ROWS;
  localparam int ColW  = $clog2(COLUMNS);
  localparam int RowW  = $clog2(ROWS);
  localparam logic [ColW-1:0] LastCol = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);
  localparam logic [PosW-1:0] LastPos = PosW'(Cells - 1);

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_EXEC, ST_PUT, ST_BS2, ST_RD, ST_DONE
  } state_e;

  state_e          state_q, ret_q;
  logic [ColW-1:0] cur_col_q;
  logic [RowW-1:0] cur_row_q;
  logic [PosW-1:0] pos_q, sweep_q;
  logic [15:0]     sweep_val_q, cell_q;
  cmd_t            cmd_q;
  logic [7:0]      code_q;
  logic [RemW-1:0] rem_q;
  logic            cleared_q;

  logic [ColW-1:0] tc;
  logic [RowW-1:0] tr;
  logic [PosW-1:0] tgt_pos;
  logic [15:0]     blank;
  logic            at_last_col, at_last_row, bs_move, printable;
  state_e          put_next;

  always_comb begin
    tc = (32'(cmd_q.col) >= 32'(COLUMNS)) ? LastCol : ColW'(cmd_q.col);
    tr = (32'(cmd_q.row) >= 32'(ROWS)) ? LastRow : RowW'(cmd_q.row);
    tgt_pos = PosW'(32'(tr) * 32'(COLUMNS) + 32'(tc));
    blank = {back_i, fore_i, 8'h00};
    at_last_col = (cur_col_q == LastCol);
    at_last_row = (cur_row_q == LastRow);
    // no bound: move unless at cell 0; bound: move only right of the bound
    bs_move = (cmd_q.bound == 7'd0) ? (pos_q != '0)
                                     : (32'(cur_col_q) > 32'(cmd_q.bound));
    printable = (cmd_q.char_code != 8'd0) && !cmd_q.char_code[7];
    put_next = (rem_q == RemW'(1)) ? ST_DONE : ST_PUT;
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = blank;
    mem_re_o    = 1'b0;
    mem_raddr_o = tgt_pos;
    case (state_q)
      ST_SWEEP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sweep_q;
        mem_wdata_o = sweep_val_q;
      end
      ST_EXEC: begin
        mem_we_o = (cmd_q.cmd == CmdBack);
        mem_re_o = (cmd_q.cmd == CmdRead);
      end
      ST_PUT: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {back_i, fore_i, code_q};
      end
      ST_BS2: begin
        mem_we_o = 1'b1;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      ret_q       <= ST_IDLE;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      pos_q       <= '0;
      sweep_q     <= '0;
      sweep_val_q <= '0;
      rem_q       <= '0;
      cleared_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_SWEEP: begin
          if (sweep_q == LastPos) begin
            sweep_q <= '0;
            state_q <= ret_q;
          end else begin
            sweep_q <= sweep_q + PosW'(1);
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q     <= cmd_i;
            cleared_q <= 1'b0;
            cell_q    <= '0;
            state_q   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_DONE;
          case (cmd_q.cmd)
            CmdPut: begin
              if (cmd_q.char_code == ChNewline) begin
                if (at_last_row) begin
                  cur_col_q   <= '0;
                  cur_row_q   <= '0;
                  pos_q       <= '0;
                  sweep_val_q <= blank;
                  cleared_q   <= 1'b1;
                  ret_q       <= ST_DONE;
                  state_q     <= ST_SWEEP;
                end else begin
                  cur_col_q <= '0;
                  cur_row_q <= cur_row_q + RowW'(1);
                  pos_q     <= pos_q + PosW'(COLUMNS) - PosW'(cur_col_q);
                end
              end else if (cmd_q.char_code == ChTab) begin
                code_q  <= ChSpace;
                rem_q   <= RemW'(TabBlanks);
                state_q <= ST_PUT;
              end else if (printable) begin
                code_q  <= cmd_q.char_code;
                rem_q   <= RemW'(1);
                state_q <= ST_PUT;
              end
            end
            CmdBack: begin
              if (bs_move) begin
                pos_q <= pos_q - PosW'(1);
                if (cur_col_q != '0) begin
                  cur_col_q <= cur_col_q - ColW'(1);
                end else begin
                  cur_col_q <= LastCol;
                  cur_row_q <= cur_row_q - RowW'(1);
                end
                state_q <= ST_BS2;
              end
            end
            CmdGoto: begin
              cur_col_q <= tc;
              cur_row_q <= tr;
              pos_q     <= tgt_pos;
            end
            CmdClear: begin
              cur_col_q   <= '0;
              cur_row_q   <= '0;
              pos_q       <= '0;
              sweep_val_q <= blank;
              cleared_q   <= 1'b1;
              ret_q       <= ST_DONE;
              state_q     <= ST_SWEEP;
            end
            CmdRead: begin
              state_q <= ST_RD;
            end
            default: begin
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_PUT: begin
          // cell is written this cycle, then the cursor advances
          rem_q <= rem_q - RemW'(1);
          if (at_last_col && at_last_row) begin
            cur_col_q   <= '0;
            cur_row_q   <= '0;
            pos_q       <= '0;
            sweep_val_q <= blank;
            cleared_q   <= 1'b1;
            ret_q       <= put_next;
            state_q     <= ST_SWEEP;
          end else begin
            if (at_last_col) begin
              cur_col_q <= '0;
              cur_row_q <= cur_row_q + RowW'(1);
            end else begin
              cur_col_q <= cur_col_q + ColW'(1);
            end
            pos_q   <= pos_q + PosW'(1);
            state_q <= put_next;
          end
        end
        ST_BS2: begin
          state_q <= ST_DONE;
        end
        ST_RD: begin
          cell_q  <= mem_rdata_i;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o = '{cursor_col:     7'(cur_col_q),
                   cursor_row:     5'(cur_row_q),
                   cell_value:     cell_q,
                   screen_cleared: cleared_q};

  // write position tracks the cursor between commands
  a_pos_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |->
      32'(pos_q) == 32'(cur_row_q) * 32'(COLUMNS) + 32'(cur_col_q))
    else $error("write position out of step with cursor");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_col_q) < 32'(COLUMNS) && 32'(cur_row_q) < 32'(ROWS))
    else $error("cursor outside the screen");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_o |=> state_q == ST_EXEC && !cleared_q)
    else $error("accepted word not executed next cycle");

  a_sweep_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP && sweep_q != '0 |->
      32'(sweep_q) < Cells && $stable(ret_q))
    else $error("clearing sweep out of range or return state changed");

endmodule
